// ===== design/bdpl_pkg.sv =====
// Shared types and constants for the button debouncer with press lockout.
`timescale 1ns / 1ps
`default_nettype none

package bdpl_pkg;

    // Width of the millisecond timestamp.
    localparam int unsigned TS_W    = 32;
    // Width of the per-button bit fields on the ports.
    localparam int unsigned FIELD_W = 3;
    // Width of the configuration registers.
    localparam int unsigned CFG_W   = 16;
    // Width of the configuration register index.
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT  = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd40;
    localparam logic [CFG_W-1:0] LOCKOUT_RESET  = 16'd160;

    // What one lane reports for the current item.
    typedef struct packed {
        logic pulse;
        logic held;
    } t_lane_res;

endpackage

`default_nettype wire

// ===== design/bdpl_lane.sv =====
// One button lane: raw change tracking, debounce settling and press lockout.
`timescale 1ns / 1ps
`default_nettype none

module bdpl_lane (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic                            i_raw,
    input  wire logic [bdpl_pkg::TS_W-1:0]       i_now,
    input  wire logic [bdpl_pkg::CFG_W-1:0]      i_debounce,
    input  wire logic [bdpl_pkg::CFG_W-1:0]      i_lockout,
    output bdpl_pkg::t_lane_res                  o_res
);

    logic                      r_last_raw;
    logic                      r_stable;
    logic                      r_armed;
    logic [bdpl_pkg::TS_W-1:0] r_change_stamp;
    logic [bdpl_pkg::TS_W-1:0] r_press_stamp;

    logic                      raw_chg;
    logic                      held_long;
    logic                      settle;
    logic                      blocked;
    logic                      pulse;
    logic [bdpl_pkg::TS_W-1:0] since_chg;
    logic [bdpl_pkg::TS_W-1:0] since_press;

    // Work out whether the level settles and whether a press may pulse
    always_comb begin
        raw_chg     = i_raw != r_last_raw;
        since_chg   = i_now - r_change_stamp;
        since_press = i_now - r_press_stamp;
        // a fresh change has held for zero ms
        held_long   = raw_chg ? (i_debounce == '0)
                              : (since_chg >= bdpl_pkg::TS_W'(i_debounce));
        settle      = held_long && (i_raw != r_stable);
        blocked     = r_armed && (since_press < bdpl_pkg::TS_W'(i_lockout));
        pulse       = settle && i_raw && !blocked;
        o_res.pulse = pulse;
        o_res.held  = settle ? i_raw : r_stable;
    end

    // Advance lane state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw     <= 1'b0;
            r_stable       <= 1'b0;
            r_armed        <= 1'b0;
            r_change_stamp <= '0;
            r_press_stamp  <= '0;
        end else if (i_accept) begin
            r_last_raw <= i_raw;
            if (raw_chg) begin
                r_change_stamp <= i_now;
            end
            if (settle) begin
                r_stable <= i_raw;
            end
            if (pulse) begin
                r_press_stamp <= i_now;
                r_armed       <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/bdpl_merge.sv =====
// Merge of the lane results into output bit fields, with output and skid registers.
`timescale 1ns / 1ps
`default_nettype none

module bdpl_merge #(
    parameter int unsigned NUM_BUTTONS = 3
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire bdpl_pkg::t_lane_res [NUM_BUTTONS-1:0] i_res,
    output logic                                     o_in_ready,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [bdpl_pkg::FIELD_W-1:0]             o_press_pulse_bits,
    output logic [bdpl_pkg::FIELD_W-1:0]             o_held_bits
);

    logic [bdpl_pkg::FIELD_W-1:0] pulse_bits;
    logic [bdpl_pkg::FIELD_W-1:0] held_bits;

    logic                         r_out_v;
    logic [bdpl_pkg::FIELD_W-1:0] r_out_pulse;
    logic [bdpl_pkg::FIELD_W-1:0] r_out_held;
    logic                         r_skid_v;
    logic [bdpl_pkg::FIELD_W-1:0] r_skid_pulse;
    logic [bdpl_pkg::FIELD_W-1:0] r_skid_held;

    // Gather lane bits; field bits with no lane read as released
    for (genvar g = 0; g < bdpl_pkg::FIELD_W; g++) begin : g_bits
        if (g < NUM_BUTTONS) begin : g_lane
            assign pulse_bits[g] = i_res[g].pulse;
            assign held_bits[g]  = i_res[g].held;
        end else begin : g_none
            assign pulse_bits[g] = 1'b0;
            assign held_bits[g]  = 1'b0;
        end
    end

    assign o_in_ready         = !r_skid_v;
    assign o_out_valid        = r_out_v;
    assign o_press_pulse_bits = r_out_pulse;
    assign o_held_bits        = r_out_held;

    // Hold the result; park a new item in the skid stage while the output stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_out_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_accept;
            end
        end else if (i_accept) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload moves alongside the valid bits
    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_out_ready) begin
            if (r_skid_v) begin
                r_out_pulse <= r_skid_pulse;
                r_out_held  <= r_skid_held;
            end else if (i_accept) begin
                r_out_pulse <= pulse_bits;
                r_out_held  <= held_bits;
            end
        end else if (i_accept) begin
            r_skid_pulse <= pulse_bits;
            r_skid_held  <= held_bits;
        end
    end

endmodule

`default_nettype wire

// ===== design/button_debounce_with_press_lockout_core.sv =====
// Top level of the button debouncer with press lockout: config, lanes and merge.
//
//  channel | valid       | ready        | payload
//  --------+-------------+--------------+-------------------------------------------
//  input   | i_in_valid  | o_in_ready   | i_now_ms[31:0], i_raw_pressed_bits[2:0]
//  output  | o_out_valid | i_out_ready  | o_press_pulse_bits[2:0], o_held_bits[2:0]
//  config  | i_cfg_valid | o_cfg_ready  | i_cfg_index[1:0], i_cfg_data[15:0]
//
//  One item is taken every clock while o_in_ready is high; its result is registered.
//  Each lane settles its level with one subtract and compare against the change stamp.
//  An output register plus a one-entry skid register keep input acceptance going
//  for one item while the output stalls; o_in_ready drops only when both are full.
//  Synchronous active-low reset: levels released, lockout disarmed, timings 40/160 ms.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_with_press_lockout_core #(
    parameter int unsigned NUM_BUTTONS = 3
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [bdpl_pkg::TS_W-1:0]           i_now_ms,
    input  wire logic [bdpl_pkg::FIELD_W-1:0]        i_raw_pressed_bits,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [bdpl_pkg::FIELD_W-1:0]             o_press_pulse_bits,
    output logic [bdpl_pkg::FIELD_W-1:0]             o_held_bits,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bdpl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bdpl_pkg::CFG_W-1:0]          i_cfg_data
);

    logic                                 accept;
    logic [bdpl_pkg::CFG_W-1:0]           r_debounce;
    logic [bdpl_pkg::CFG_W-1:0]           r_lockout;
    bdpl_pkg::t_lane_res [NUM_BUTTONS-1:0] lane_res;

    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= bdpl_pkg::DEBOUNCE_RESET;
            r_lockout  <= bdpl_pkg::LOCKOUT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bdpl_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                bdpl_pkg::CFG_LOCKOUT:  r_lockout  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // One lane per button; lanes past the field width see released
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic lane_raw;
        if (g < bdpl_pkg::FIELD_W) begin : g_pin
            assign lane_raw = i_raw_pressed_bits[g];
        end else begin : g_idle
            assign lane_raw = 1'b0;
        end

        bdpl_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_accept   (accept),
            .i_raw      (lane_raw),
            .i_now      (i_now_ms),
            .i_debounce (r_debounce),
            .i_lockout  (r_lockout),
            .o_res      (lane_res[g])
        );
    end

    bdpl_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_res              (lane_res),
        .o_in_ready         (o_in_ready),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_press_pulse_bits (o_press_pulse_bits),
        .o_held_bits        (o_held_bits)
    );

`ifndef SYNTH
    // Input back-pressure only ever comes from a stalled, full output side
    a_ready_low_needs_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    // An accepted item always leaves a result behind it
    a_accept_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted item produced no result");

    // A press pulse only comes with a held level
    a_pulse_implies_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_press_pulse_bits & ~o_held_bits) == '0))
        else $error("press pulse on a released button");
`endif

endmodule

`default_nettype wire
